### hw/rtl/ats_pkg.sv
// Shared types and constants for the annealing tour swap engine.
// No dependencies.
package ats_pkg;

  localparam int CITY_COUNT_DEF = 20;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] START_TEMP_RST = 16'd25600;
  localparam logic [15:0] END_TEMP_RST   = 16'd256;
  localparam logic [19:0] MOVES_RST      = 20'd10000;

  localparam logic [1:0] FN_WRITE   = 2'd0;
  localparam logic [1:0] FN_PROPOSE = 2'd1;
  localparam logic [1:0] FN_READ    = 2'd2;
  localparam logic [1:0] FN_RESTART = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  localparam logic [1:0] CFG_START_TEMP = 2'd0;
  localparam logic [1:0] CFG_END_TEMP   = 2'd1;
  localparam logic [1:0] CFG_MOVES      = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  row_city;
    logic [5:0]  col_city;
    logic [15:0] distance_value;
    logic [5:0]  swap_a;
    logic [5:0]  swap_b;
    logic [15:0] neg_log_rand;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        accepted;
    logic [21:0] candidate_length;
    logic [21:0] current_length;
    logic [5:0]  tour_city;
    logic [15:0] temperature_now;
  } out_item_t;

  typedef struct packed {
    logic     bad;
    in_item_t item;
  } q_item_t;

endpackage

### hw/rtl/ats_front.sv
// Front end: accepts items and flags out-of-range indexes.
// Uses ats_pkg; feeds ats_queue.
module ats_front #(
  parameter int CITY_COUNT = ats_pkg::CITY_COUNT_DEF
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  ats_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output ats_pkg::q_item_t  q_data
);

  localparam logic [6:0] CC7 = 7'(CITY_COUNT);

  logic row_bad, col_bad, a_bad, b_bad;

  always_comb begin
    row_bad = {1'b0, in_data.row_city} >= CC7;
    col_bad = {1'b0, in_data.col_city} >= CC7;
    a_bad   = {1'b0, in_data.swap_a} >= CC7;
    b_bad   = {1'b0, in_data.swap_b} >= CC7;
    q_data.item = in_data;
    case (in_data.func)
      ats_pkg::FN_WRITE:   q_data.bad = row_bad | col_bad;
      ats_pkg::FN_PROPOSE: q_data.bad = a_bad | b_bad;
      ats_pkg::FN_READ:    q_data.bad = a_bad;
      default:             q_data.bad = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

endmodule

### hw/rtl/ats_queue.sv
// Short queue between front and back end.
// Uses ats_pkg.
module ats_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ats_pkg::q_item_t push_data,
  input  logic             pop,
  output ats_pkg::q_item_t head,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(ats_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(ats_pkg::QUEUE_DEPTH + 1);

  ats_pkg::q_item_t slot_r [ats_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign head  = slot_r[rp_r];
  assign full  = cnt_r == CW'(ats_pkg::QUEUE_DEPTH);
  assign empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(ats_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(ats_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule

### hw/rtl/ats_back.sv
// Back end: distance memory, tour, length walk, acceptance and cooling.
// Uses ats_pkg; pops ats_queue and drives the result register.
module ats_back #(
  parameter int CITY_COUNT = ats_pkg::CITY_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  ats_pkg::q_item_t   head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ats_pkg::out_item_t out_data
);

  localparam int CW = $clog2(CITY_COUNT);
  localparam int KW = $clog2(CITY_COUNT + 1);
  localparam int AW = $clog2(CITY_COUNT * CITY_COUNT);
  localparam int DEPTH = CITY_COUNT * CITY_COUNT;
  localparam logic [AW-1:0] CC_A = AW'(CITY_COUNT);

  typedef enum logic [1:0] {IDLE, WALK, DRAIN, DECIDE} state_t;

  state_t state_r;
  logic [15:0] mem [DEPTH];
  logic [15:0] rd_r;
  logic        rdv_r;
  logic [CW-1:0] tour_r [CITY_COUNT];
  logic [21:0] len_r, sum_r;
  logic [15:0] temp_r, start_r, end_r;
  logic [19:0] cnt_r, mpl_r;
  logic [31:0] prod_r;
  logic [KW-1:0] k_r;
  logic [CW-1:0] a_r, b_r, prev_r, va_r, vb_r;
  logic        rst_job_r;
  logic        out_valid_r;
  ats_pkg::out_item_t out_r;

  logic          slot_free;
  logic [CW-1:0] pos, rdpos, city;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          mem_we;
  logic [21:0]   delta;
  logic          acc;
  logic          lvl_end;
  logic [15:0]   temp_nxt;
  logic [20:0]   cnt_inc;

  assign slot_free = ~out_valid_r | ~out_stall;
  assign q_pop     = (state_r == IDLE) & ~q_empty & slot_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    pos = (k_r == KW'(CITY_COUNT)) ? '0 : k_r[CW-1:0];
    if (state_r == IDLE) begin
      rdpos = head.item.swap_a[CW-1:0];
    end else if (pos == a_r) begin
      rdpos = b_r;
    end else if (pos == b_r) begin
      rdpos = a_r;
    end else begin
      rdpos = pos;
    end
    city    = tour_r[rdpos];
    rd_addr = AW'(prev_r) * CC_A + AW'(city);
    wr_addr = AW'(head.item.row_city[CW-1:0]) * CC_A + AW'(head.item.col_city[CW-1:0]);
    mem_we  = q_pop & ~head.bad & (head.item.func == ats_pkg::FN_WRITE);
    delta   = sum_r - len_r;
    acc     = (sum_r < len_r) ||
              ((delta[21:12] == '0) && ({delta[11:0], 20'd0} < prod_r));
    cnt_inc = {1'b0, cnt_r} + 21'd1;
    lvl_end = cnt_inc >= {1'b0, mpl_r};
    temp_nxt = lvl_end ? (temp_r >> 1) : temp_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= head.item.distance_value;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
      len_r       <= '0;
      temp_r      <= ats_pkg::START_TEMP_RST;
      start_r     <= ats_pkg::START_TEMP_RST;
      end_r       <= ats_pkg::END_TEMP_RST;
      mpl_r       <= ats_pkg::MOVES_RST;
      cnt_r       <= '0;
      for (int i = 0; i < CITY_COUNT; i++) begin
        tour_r[i] <= CW'(i);
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          ats_pkg::CFG_START_TEMP: start_r <= cfg_data[15:0];
          ats_pkg::CFG_END_TEMP:   end_r   <= cfg_data[15:0];
          ats_pkg::CFG_MOVES:      mpl_r   <= cfg_data;
          default: ;
        endcase
      end
      if (slot_free) begin
        out_valid_r <= 1'b0;
      end
      rdv_r <= 1'b0;
      case (state_r)
        IDLE: begin
          if (q_pop) begin
            out_r.status           <= ats_pkg::ST_OK;
            out_r.accepted         <= 1'b0;
            out_r.candidate_length <= '0;
            out_r.current_length   <= len_r;
            out_r.tour_city        <= '0;
            out_r.temperature_now  <= temp_r;
            a_r       <= head.item.swap_a[CW-1:0];
            b_r       <= head.item.swap_b[CW-1:0];
            k_r       <= '0;
            sum_r     <= '0;
            rst_job_r <= 1'b0;
            prod_r    <= temp_r * head.item.neg_log_rand;
            if (head.bad) begin
              out_r.status <= ats_pkg::ST_RANGE;
              out_valid_r  <= 1'b1;
            end else begin
              case (head.item.func)
                ats_pkg::FN_PROPOSE: begin
                  if (temp_r <= end_r) begin
                    out_r.status <= ats_pkg::ST_DONE;
                    out_valid_r  <= 1'b1;
                  end else begin
                    state_r <= WALK;
                  end
                end
                ats_pkg::FN_READ: begin
                  out_r.tour_city <= 6'(city);
                  out_valid_r     <= 1'b1;
                end
                ats_pkg::FN_RESTART: begin
                  for (int i = 0; i < CITY_COUNT; i++) begin
                    tour_r[i] <= CW'(i);
                  end
                  a_r       <= '0;
                  b_r       <= '0;
                  rst_job_r <= 1'b1;
                  state_r   <= WALK;
                end
                default: out_valid_r <= 1'b1;
              endcase
            end
          end
        end
        WALK: begin
          prev_r <= city;
          if (pos == a_r) va_r <= city;
          if (pos == b_r) vb_r <= city;
          rdv_r <= k_r != '0;
          if (rdv_r) sum_r <= sum_r + 22'(rd_r);
          k_r <= k_r + 1'b1;
          if (k_r == KW'(CITY_COUNT)) state_r <= DRAIN;
        end
        DRAIN: begin
          if (rdv_r) sum_r <= sum_r + 22'(rd_r);
          state_r <= DECIDE;
        end
        DECIDE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= IDLE;
            if (rst_job_r) begin
              len_r                  <= sum_r;
              temp_r                 <= start_r;
              cnt_r                  <= '0;
              out_r.current_length   <= sum_r;
              out_r.temperature_now  <= start_r;
            end else begin
              out_r.accepted         <= acc;
              out_r.candidate_length <= sum_r;
              out_r.current_length   <= acc ? sum_r : len_r;
              out_r.temperature_now  <= temp_nxt;
              temp_r                 <= temp_nxt;
              cnt_r                  <= lvl_end ? '0 : cnt_inc[19:0];
              if (acc) begin
                len_r       <= sum_r;
                tour_r[a_r] <= va_r;
                tour_r[b_r] <= vb_r;
              end
            end
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/annealing_tour_swap_engine.sv
// Top level of the annealing tour swap engine.
// Uses ats_pkg, ats_front, ats_queue and ats_back.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | ats_pkg::in_item_t
//   out_    | output    | out_valid/out_stall| ats_pkg::out_item_t
//   cfg_    | input     | cfg_valid/ready    | cfg_index, cfg_data
//
// Write, read, out-of-range and finished items are answered straight from the idle state of the back end.
// Propose and restart make one distance memory read per tour edge, plus issue, drain
// and decide steps; decide waits while a result is held by out_stall.
// Synchronous active-low reset; tour resets to identity, the distance memory is not cleared.
// A two-entry queue lets input transfers continue while a result waits on out_stall.
module annealing_tour_swap_engine #(
  parameter int CITY_COUNT = ats_pkg::CITY_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ats_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ats_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  logic             q_push, q_pop, q_full, q_empty;
  ats_pkg::q_item_t q_in, q_head;

  assign cfg_ready = 1'b1;

  ats_front #(.CITY_COUNT(CITY_COUNT)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  ats_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  ats_back #(.CITY_COUNT(CITY_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
